FILE: hw/rtl/vfhd_pkg.sv
`default_nettype none
package vfhd_pkg;
    localparam int unsigned HDR_BYTES = 64;
    localparam int unsigned POS_W = 34;
    // Byte position at which pitch and height are both captured, so the
    // payload size product can be registered well before the header ends.
    localparam int unsigned PROD_POS = 32;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_HDR_TRUNC   = 3'd1;
    localparam logic [2:0] ST_SCHEMA      = 3'd2;
    localparam logic [2:0] ST_HDR_SIZE    = 3'd3;
    localparam logic [2:0] ST_METADATA    = 3'd4;
    localparam logic [2:0] ST_SIZE_MISM   = 3'd5;
    localparam logic [2:0] ST_PAY_TRUNC   = 3'd6;

    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    // Output beat layout of tdata, lowest bit first.
    localparam int unsigned OUT_W = 8 + 32 * 4 + 64 * 4 + 3; // 395
    localparam int unsigned OUT_TDATA_W = 400;

    // Command passed from the front part to the back part.
    typedef struct packed {
        logic       kind;     // 0 payload byte, 1 summary
        logic [7:0] data;
        logic [2:0] status;
    } vfhd_cmd_t;

    // Decoded header fields held while a frame is open.
    typedef struct packed {
        logic [63:0] epoch_lower;
        logic [63:0] epoch_upper;
        logic [63:0] timestamp_ms;
        logic [63:0] frame_number;
        logic [31:0] pixel_format;
        logic [31:0] frame_pitch;
        logic [31:0] frame_height;
        logic [31:0] frame_width;
    } vfhd_hdr_t;
endpackage
`default_nettype wire

FILE: hw/rtl/video_frame_header_deframer_unit.sv
`default_nettype none
// An accepted byte is written into the queue and is sent from its head.
// Throughput: one byte per cycle while the queue is not full; a final byte
// that also carries a payload byte yields two output beats.
// A four-entry queue between the byte counter and the output absorbs stalls.
// Reset (aresetn low, synchronous) clears the counter, header, queue and registers.
module video_frame_header_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH_LOG2 = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // end_of_buffer
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: payload_byte, frame_width, frame_height, frame_pitch, pixel_format,
    // frame_number, timestamp_ms, epoch_upper, epoch_lower, status, zero fill
    output logic [vfhd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic              m_tuser,   // result_kind
    output logic              m_tlast,   // last_flag
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);
    logic [31:0] magic_reg, version_reg;
    logic push, full, c0v, c1v;
    vfhd_pkg::vfhd_cmd_t c0, c1;
    vfhd_pkg::vfhd_hdr_t hdr;
    logic [vfhd_pkg::OUT_TDATA_W-1:0] raw;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= '0;
            version_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vfhd_pkg::CFG_MAGIC:   magic_reg <= cfg_data;
                vfhd_pkg::CFG_VERSION: version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vfhd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata), .in_last(s_tlast),
        .exp_magic(magic_reg), .exp_version(version_reg),
        .push(push), .full(full),
        .cmd0_vld(c0v), .cmd0(c0), .cmd1_vld(c1v), .cmd1(c1), .hdr_out(hdr)
    );

    vfhd_back #(.DEPTH_LOG2(QUEUE_DEPTH_LOG2)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .full(full),
        .cmd0_vld(c0v), .cmd0(c0), .cmd1_vld(c1v), .cmd1(c1), .hdr_in(hdr),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(raw), .out_last(m_tlast)
    );

    // Kind bit goes to tuser; tdata holds the remaining fields.
    assign m_tuser = raw[0];
    assign m_tdata = {1'b0, raw[vfhd_pkg::OUT_TDATA_W-1:1]};
endmodule
`default_nettype wire

FILE: hw/rtl/vfhd_front.sv
`default_nettype none
// Front part: counts bytes, captures the header, checks it and issues commands.
// Each beat may give a payload command and a summary command; both are pushed
// together as a pair so the queue sees one entry per accepted beat.
module vfhd_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_last,
    input  wire logic [31:0]         exp_magic,
    input  wire logic [31:0]         exp_version,
    output logic                     push,
    input  wire logic                full,
    output logic                     cmd0_vld,
    output vfhd_pkg::vfhd_cmd_t      cmd0,
    output logic                     cmd1_vld,
    output vfhd_pkg::vfhd_cmd_t      cmd1,
    output vfhd_pkg::vfhd_hdr_t      hdr_out
);
    logic [vfhd_pkg::POS_W-1:0] pos_reg;
    logic [31:0] magic_reg, version_reg, hsize_reg, psize_reg;
    logic [31:0] dims_reg [4];
    logic [63:0] wide_reg [4];
    logic [2:0]  err_reg;
    // The pitch times height product is registered once both are captured,
    // so the whole header check settles within the last header byte.
    logic [63:0] prod_reg;
    logic [2:0]  verdict;
    logic        hdr_last;
    logic [2:0]  err_now;
    logic [vfhd_pkg::POS_W:0] win_hi;
    logic [vfhd_pkg::POS_W:0] seen_len;
    logic        in_win;
    logic [2:0]  st;
    logic        acc;

    assign in_ready = !full;
    assign acc = in_valid && in_ready;
    assign push = acc;

    // Header check in order: schema, header size, metadata, payload size.
    always_comb begin
        if (magic_reg != exp_magic || version_reg != exp_version) begin
            verdict = vfhd_pkg::ST_SCHEMA;
        end else if (hsize_reg < 32'(vfhd_pkg::HDR_BYTES)) begin
            verdict = vfhd_pkg::ST_HDR_SIZE;
        end else if (dims_reg[0] == '0 || dims_reg[1] == '0 || dims_reg[2] == '0
                || dims_reg[3] == '0 || wide_reg[0] == '0) begin
            verdict = vfhd_pkg::ST_METADATA;
        end else if ({32'd0, psize_reg} != prod_reg) begin
            verdict = vfhd_pkg::ST_SIZE_MISM;
        end else begin
            verdict = vfhd_pkg::ST_OK;
        end
    end

    // On the last header byte the verdict is used directly; later on it is held.
    assign hdr_last = (pos_reg == vfhd_pkg::POS_W'(vfhd_pkg::HDR_BYTES - 1));
    assign err_now = hdr_last ? verdict : err_reg;

    assign win_hi = {3'd0, hsize_reg} + {3'd0, psize_reg};
    assign in_win = ({1'b0, pos_reg} >= {3'd0, hsize_reg}) && ({1'b0, pos_reg} < win_hi);
    assign seen_len = {1'b0, pos_reg} + 1'b1;

    // Command generation for the current beat.
    always_comb begin
        cmd0 = '0;
        cmd1 = '0;
        cmd0_vld = 1'b0;
        cmd1_vld = in_last;
        cmd0.data = in_byte;
        if (pos_reg >= vfhd_pkg::POS_W'(vfhd_pkg::HDR_BYTES) && err_now == vfhd_pkg::ST_OK
                && in_win) begin
            cmd0_vld = 1'b1;
        end
        if (seen_len < (vfhd_pkg::POS_W + 1)'(vfhd_pkg::HDR_BYTES)) begin
            st = vfhd_pkg::ST_HDR_TRUNC;
        end else if (err_now != vfhd_pkg::ST_OK) begin
            st = err_now;
        end else if (seen_len < win_hi) begin
            st = vfhd_pkg::ST_PAY_TRUNC;
        end else begin
            st = vfhd_pkg::ST_OK;
        end
        cmd1.kind = 1'b1;
        cmd1.status = st;
    end

    // Header fields for the summary.
    assign hdr_out.frame_width  = dims_reg[0];
    assign hdr_out.frame_height = dims_reg[1];
    assign hdr_out.frame_pitch  = dims_reg[2];
    assign hdr_out.pixel_format = dims_reg[3];
    assign hdr_out.frame_number = wide_reg[0];
    assign hdr_out.timestamp_ms = wide_reg[1];
    assign hdr_out.epoch_upper  = wide_reg[2];
    assign hdr_out.epoch_lower  = wide_reg[3];

    // Byte counter, header capture and check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            magic_reg <= '0;
            version_reg <= '0;
            hsize_reg <= '0;
            psize_reg <= '0;
            err_reg <= '0;
            prod_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                dims_reg[i] <= '0;
                wide_reg[i] <= '0;
            end
        end else if (acc) begin
            if (in_last) begin
                // End of buffer: the frame state starts over.
                pos_reg <= '0;
                magic_reg <= '0;
                version_reg <= '0;
                hsize_reg <= '0;
                psize_reg <= '0;
                err_reg <= '0;
                prod_reg <= '0;
                for (int i = 0; i < 4; i++) begin
                    dims_reg[i] <= '0;
                    wide_reg[i] <= '0;
                end
            end else begin
                if (pos_reg < vfhd_pkg::POS_W'(vfhd_pkg::HDR_BYTES)) begin
                    unique case (pos_reg[5:2])
                        4'd0: magic_reg[pos_reg[1:0]*8 +: 8] <= in_byte;
                        4'd1: version_reg[pos_reg[1:0]*8 +: 8] <= in_byte;
                        4'd2: hsize_reg[pos_reg[1:0]*8 +: 8] <= in_byte;
                        4'd3, 4'd4, 4'd5, 4'd6:
                            dims_reg[2'(pos_reg[5:2] - 4'd3)][pos_reg[1:0]*8 +: 8] <= in_byte;
                        4'd7: psize_reg[pos_reg[1:0]*8 +: 8] <= in_byte;
                        default:
                            wide_reg[2'(pos_reg[4:3])][pos_reg[2:0]*8 +: 8] <= in_byte;
                    endcase
                end
                if (pos_reg == vfhd_pkg::POS_W'(vfhd_pkg::PROD_POS)) begin
                    prod_reg <= {32'd0, dims_reg[2]} * {32'd0, dims_reg[1]};
                end
                if (hdr_last) begin
                    err_reg <= verdict;
                end
                if (pos_reg != '1) begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/vfhd_back.sv
`default_nettype none
// Back part: a short queue of command pairs, unrolled onto the output beat.
module vfhd_back #(
    parameter int unsigned DEPTH_LOG2 = 2
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          cmd0_vld,
    input  wire vfhd_pkg::vfhd_cmd_t           cmd0,
    input  wire logic                          cmd1_vld,
    input  wire vfhd_pkg::vfhd_cmd_t           cmd1,
    input  wire vfhd_pkg::vfhd_hdr_t           hdr_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [vfhd_pkg::OUT_TDATA_W-1:0]   out_data,
    output logic                               out_last
);
    localparam int unsigned DEPTH = 1 << DEPTH_LOG2;
    localparam int unsigned EW = 2 + 2 * $bits(vfhd_pkg::vfhd_cmd_t) + $bits(vfhd_pkg::vfhd_hdr_t);

    logic [EW-1:0] mem [DEPTH];
    logic [DEPTH_LOG2:0] wp_reg, rp_reg;
    logic          half_reg;
    logic [EW-1:0] head;
    logic          empty;
    logic          h0v, h1v;
    vfhd_pkg::vfhd_cmd_t h0, h1, cur;
    vfhd_pkg::vfhd_hdr_t hh;
    logic          pop;
    logic          skip;

    assign empty = (wp_reg == rp_reg);
    assign full = (wp_reg[DEPTH_LOG2] != rp_reg[DEPTH_LOG2])
                  && (wp_reg[DEPTH_LOG2-1:0] == rp_reg[DEPTH_LOG2-1:0]);
    assign head = mem[rp_reg[DEPTH_LOG2-1:0]];
    assign {h0v, h1v, h0, h1, hh} = head;

    // Entry with neither command is dropped at once; otherwise the payload
    // half goes first, then the summary half.
    assign skip = !empty && !h0v && !h1v;
    assign cur = (h0v && !half_reg) ? h0 : h1;
    assign out_valid = !empty && (h0v || h1v);
    assign pop = skip || (out_valid && out_ready && !(h0v && h1v && !half_reg));

    // Output beat: payload byte, header (summary ok only), status.
    always_comb begin
        out_data = '0;
        out_data[0] = cur.kind;
        if (!cur.kind) begin
            out_data[8:1] = cur.data;
        end else begin
            out_data[395:393] = cur.status;
            if (cur.status == vfhd_pkg::ST_OK) begin
                out_data[392:9] = {hh.epoch_lower, hh.epoch_upper,
                                   hh.timestamp_ms, hh.frame_number,
                                   hh.pixel_format, hh.frame_pitch,
                                   hh.frame_height, hh.frame_width};
            end
        end
    end
    assign out_last = cur.kind;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg[DEPTH_LOG2-1:0]] <= {cmd0_vld, cmd1_vld, cmd0, cmd1, hdr_in};
        end
    end

    // Queue pointers and half select.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            half_reg <= 1'b0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
                half_reg <= 1'b0;
            end else if (out_valid && out_ready) begin
                half_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/vfhd_checker.sv
`default_nettype none
// Port-level checks of the deframer.
module vfhd_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [399:0] m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);
    // A summary beat is always marked as last.
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast)) else $error("kind and last disagree");
    // Payload beats carry no status.
    a_pay_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[394:392] == 3'd0)) else $error("payload status");
    // Status never exceeds payload truncated.
    a_status_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[394:392] != 3'd7)) else $error("bad status");
    // A stalled beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("hold");
endmodule

bind video_frame_header_deframer_unit vfhd_checker u_vfhd_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

FILE: tb/video_frame_header_deframer_unit_checker.sv
`default_nettype none
// Watches the byte, result and register channels, predicts every result beat
// from the accepted bytes and compares it with what the block sends.
module video_frame_header_deframer_unit_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [vfhd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic         m_tuser,
    input  wire logic         m_tlast,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data,
    output int                mismatches,
    output int                outstanding
);
    import vfhd_pkg::*;

    typedef struct {
        logic                 kind;
        logic                 last;
        logic [OUT_W-1:0]     body;
    } result_beat_t;

    result_beat_t pending_results[$];

    // Shadow of the block's registers and frame state.
    logic [31:0]  magic_reg;
    logic [31:0]  version_reg;
    logic [33:0]  byte_pos;
    logic [511:0] hdr_image;
    logic [2:0]   header_status;

    assign outstanding = pending_results.size();

    function automatic logic [2:0] judge_header(logic [511:0] h);
        logic [63:0] product;
        product = 64'(h[191:160]) * 64'(h[159:128]);
        if (h[31:0] != magic_reg || h[63:32] != version_reg) return ST_SCHEMA;
        if (h[95:64] < HDR_BYTES) return ST_HDR_SIZE;
        if (h[127:96] == 0 || h[159:128] == 0 || h[191:160] == 0 || h[223:192] == 0 ||
            h[319:256] == 0) return ST_METADATA;
        if (64'(h[255:224]) != product) return ST_SIZE_MISM;
        return ST_OK;
    endfunction

    // Advances the shadow state by one accepted byte beat.
    task automatic predict_byte(logic [7:0] b, logic eob);
        result_beat_t r;
        logic [33:0]  p;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  raw_len;
        logic [2:0]   st;
        p = byte_pos;
        if (p < HDR_BYTES) begin
            hdr_image[8 * p[5:0] +: 8] = b;
            if (p == HDR_BYTES - 1) header_status = judge_header(hdr_image);
        end else if (header_status == ST_OK) begin
            lo = 64'(hdr_image[95:64]);
            hi = lo + 64'(hdr_image[255:224]);
            if (64'(p) >= lo && 64'(p) < hi) begin
                r.kind = 1'b0;
                r.last = 1'b0;
                r.body = '0;
                r.body[7:0] = b;
                pending_results.push_back(r);
            end
        end
        if (byte_pos != '1) byte_pos = byte_pos + 1;
        if (eob) begin
            raw_len = 64'(p) + 1;
            if (raw_len < HDR_BYTES) st = ST_HDR_TRUNC;
            else if (header_status != ST_OK) st = header_status;
            else if (64'(hdr_image[95:64]) > raw_len ||
                     raw_len - 64'(hdr_image[95:64]) < 64'(hdr_image[255:224]))
                st = ST_PAY_TRUNC;
            else st = ST_OK;
            r.kind = 1'b1;
            r.last = 1'b1;
            r.body = '0;
            if (st == ST_OK) begin
                r.body[391:8] = {hdr_image[511:256], hdr_image[223:96]};
            end
            r.body[394:392] = st;
            pending_results.push_back(r);
            byte_pos = '0;
            hdr_image = '0;
            header_status = ST_OK;
        end
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", fname, want, got);
        end
    endtask

    // Compares one result beat with the oldest prediction.
    task automatic check_result();
        result_beat_t w;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with nothing expected: tdata %h", m_tdata[OUT_W-1:0]);
            return;
        end
        w = pending_results.pop_front();
        check_field("result_kind", 64'(w.kind), 64'(m_tuser));
        check_field("last_flag", 64'(w.last), 64'(m_tlast));
        check_field("payload_byte", 64'(w.body[7:0]), 64'(m_tdata[7:0]));
        check_field("frame_width", 64'(w.body[39:8]), 64'(m_tdata[39:8]));
        check_field("frame_height", 64'(w.body[71:40]), 64'(m_tdata[71:40]));
        check_field("frame_pitch", 64'(w.body[103:72]), 64'(m_tdata[103:72]));
        check_field("pixel_format", 64'(w.body[135:104]), 64'(m_tdata[135:104]));
        check_field("frame_number", w.body[199:136], m_tdata[199:136]);
        check_field("timestamp_ms", w.body[263:200], m_tdata[263:200]);
        check_field("epoch_upper", w.body[327:264], m_tdata[327:264]);
        check_field("epoch_lower", w.body[391:328], m_tdata[391:328]);
        check_field("status", 64'(w.body[394:392]), 64'(m_tdata[394:392]));
    endtask

    initial begin
        mismatches = 0;
    end

    // Handshakes are sampled at the edge, before any update of that edge lands.
    always @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg = '0;
            version_reg = '0;
            byte_pos = '0;
            hdr_image = '0;
            header_status = ST_OK;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAGIC) magic_reg = cfg_data;
                else version_reg = cfg_data;
            end
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
        end
    end
endmodule
`default_nettype wire

FILE: tb/video_frame_header_deframer_unit_tb.sv
`default_nettype none
module video_frame_header_deframer_unit_tb;
    import vfhd_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;
    int           mismatches;
    int           outstanding;

    logic         no_idle;
    int           bytes_sent;
    int           stall_cycles;
    logic [31:0]  cur_magic;
    logic [31:0]  cur_version;

    video_frame_header_deframer_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    video_frame_header_deframer_unit_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The result side stalls at random unless a quiet stretch is running.
    always @(posedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);
    end

    // Watchdog: ends the run after too many cycles without any beat moving.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("video_frame_header_deframer_unit_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Ready is read at the falling edge, where it has settled for the next rise.
    task automatic send_byte(logic [7:0] b, logic eob);
        logic rdy;
        while (!no_idle && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eob;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        bytes_sent++;
    endtask

    // Holds the sender until every predicted result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge aclk);
            rdy = cfg_ready;
            @(posedge aclk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAGIC) cur_magic = value;
        else cur_version = value;
    endtask

    // Sends one buffer: header image h, total length len, pad and payload random.
    task automatic send_buffer(logic [511:0] h, int len);
        for (int i = 0; i < len; i++) begin
            send_byte(i < 64 ? h[8 * i +: 8] : 8'($urandom), i == len - 1);
        end
    endtask

    // Builds a header with random content; most are well formed, and most of
    // the rest carry one defect each.
    task automatic random_frame();
        logic [511:0] h;
        logic [31:0]  hsize;
        logic [31:0]  pitch;
        logic [31:0]  height;
        logic [63:0]  body_end;
        int           len;
        int           flaw;
        pitch = $urandom_range(1, 8);
        height = $urandom_range(1, 6);
        hsize = $urandom_range(64, 72);
        h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        h[31:0] = cur_magic;
        h[63:32] = cur_version;
        h[95:64] = hsize;
        if (h[127:96] == 0) h[127:96] = 1;
        h[159:128] = height;
        h[191:160] = pitch;
        if (h[223:192] == 0) h[223:192] = 1;
        h[255:224] = pitch * height;
        if (h[319:256] == 0) h[319:256] = 1;
        body_end = 64'(hsize) + 64'(pitch * height);
        len = int'(body_end) + $urandom_range(0, 3);
        flaw = $urandom_range(99) < 65 ? 0 : $urandom_range(1, 10);
        case (flaw)
            1: h[8 * $urandom_range(0, 3) +: 8] ^= 8'(1 << $urandom_range(0, 7));
            2: h[32 + 8 * $urandom_range(0, 3) +: 8] ^= 8'(1 << $urandom_range(0, 7));
            3: h[95:64] = $urandom_range(0, 63);
            4: begin
                case ($urandom_range(0, 4))
                    0: h[127:96] = '0;
                    1: h[159:128] = '0;
                    2: h[191:160] = '0;
                    3: h[223:192] = '0;
                    default: h[319:256] = '0;
                endcase
            end
            5: h[255:224] = h[255:224] + $urandom_range(1, 3);
            6: len = $urandom_range(1, 63);
            7: len = $urandom_range(64, int'(body_end) - 1);
            8: h[95:64] = 32'hFFFF_FFFF;
            9: h[95:64] = $urandom_range(64, 200);
            default: ;
        endcase
        send_buffer(h, len);
    endtask

    task automatic run_phase(int upto, logic quiet);
        no_idle = quiet;
        while (bytes_sent < upto) random_frame();
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        logic [511:0] h;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAGIC;
        cfg_data = '0;
        no_idle = 1'b0;
        bytes_sent = 0;
        stall_cycles = 0;
        cur_magic = '0;
        cur_version = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tiny buffers, then one frame with extreme field values
        // under the reset register values.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        h = '0;
        h[95:64] = 64;
        h[127:96] = 32'hFFFF_FFFF;
        h[159:128] = 1;
        h[191:160] = 1;
        h[223:192] = 32'hFFFF_FFFF;
        h[255:224] = 1;
        h[319:256] = 64'hFFFF_FFFF_FFFF_FFFF;
        h[383:320] = 64'h8000_0000_0000_0000;
        h[447:384] = 64'h7FFF_FFFF_FFFF_FFFF;
        h[511:448] = 64'hFFFF_FFFF_FFFF_FFFF;
        send_buffer(h, 65);
        drain();

        run_phase(250, 1'b0);
        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_VERSION, 32'hFFFF_FFFF);
        run_phase(500, 1'b0);
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, $urandom);
        run_phase(700, 1'b1);
        write_reg(CFG_MAGIC, 32'h0);
        write_reg(CFG_VERSION, $urandom);
        run_phase(1050, 1'b0);

        if (mismatches == 0 && outstanding == 0) begin
            $display("video_frame_header_deframer_unit_tb: done, clean");
        end else begin
            $display("video_frame_header_deframer_unit_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: video_frame_header_deframer_unit.f
hw/rtl/vfhd_pkg.sv
hw/rtl/vfhd_front.sv
hw/rtl/vfhd_back.sv
hw/rtl/video_frame_header_deframer_unit.sv
hw/rtl/vfhd_checker.sv
tb/video_frame_header_deframer_unit_checker.sv
tb/video_frame_header_deframer_unit_tb.sv
